@@ design/ycgdec_pkg.sv @@
package ycgdec_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned BlockBits = 192;

  localparam logic CfgFormatSelect = 1'b0;
  localparam logic CfgAlphaEnable  = 1'b1;

  localparam logic Layout420 = 1'b0;
  localparam logic Layout422 = 1'b1;

  localparam logic [1:0] LastRow = 2'd3;

  localparam logic [4:0] CoBase      = 5'd0;
  localparam logic [4:0] CgBase420   = 5'd2;
  localparam logic [4:0] CgBase422   = 5'd4;
  localparam logic [4:0] LumaBase420 = 5'd4;
  localparam logic [4:0] LumaBase422 = 5'd8;
  localparam logic [4:0] AlphaBase420 = 5'd12;
  localparam logic [4:0] AlphaBase422 = 5'd16;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  localparam logic [3:0] NibOfPixel [16] = '{
    4'd0, 4'd1, 4'd4, 4'd5, 4'd2, 4'd3, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd12, 4'd13, 4'd10, 4'd11, 4'd14, 4'd15
  };

  typedef struct packed {
    logic format_select;
    logic alpha_enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0][3:0] co;
    logic [3:0][3:0] cg;
    logic [3:0][3:0] luma;
    logic [3:0][7:0] alpha;
  } row_t;

  typedef struct packed {
    row_t [3:0] rows;
  } entry_t;

  function automatic logic [3:0] get_nib(logic [BlockBits-1:0] blk, logic [4:0] base,
                                         logic [3:0] k);
    logic [4:0] byte_idx;
    logic [7:0] bit_idx;
    byte_idx = base + {2'b00, k[3:1]};
    bit_idx  = {byte_idx, k[0], 2'b00};
    return blk[bit_idx +: 4];
  endfunction

  function automatic logic [7:0] clamp240(logic signed [10:0] v);
    logic [7:0] res;
    if (v < 11'sd0) begin
      res = 8'd0;
    end else if (v > 11'sd240) begin
      res = 8'd240;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] scale_out(logic [7:0] v);
    logic [11:0] t;
    t = {v, 4'b0000} + {4'b0000, v} + 12'd8;
    return t[11:4];
  endfunction

  function automatic logic [31:0] make_pixel(logic [3:0] co, logic [3:0] cg,
                                             logic [3:0] luma, logic [7:0] alpha);
    logic signed [10:0] c;
    logic signed [10:0] o;
    logic signed [10:0] n;
    logic signed [10:0] g;
    logic signed [10:0] b;
    logic signed [10:0] r;
    logic [7:0] gc;
    logic [7:0] bc;
    logic [7:0] rc;
    c  = $signed({7'b0, cg}) - 11'sd7;
    o  = $signed({7'b0, co}) - 11'sd7;
    n  = $signed({3'b0, luma, 4'b0000});
    g  = n + c * 11'sd15;
    b  = n - c * 11'sd15 - o * 11'sd15;
    gc = clamp240(g);
    bc = clamp240(b);
    r  = $signed({3'b0, bc}) + o * 11'sd30;
    rc = clamp240(r);
    return {alpha, scale_out(bc), scale_out(gc), scale_out(rc)};
  endfunction

endpackage

@@ design/ycgdec_blk_if.sv @@
interface ycgdec_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] head_bytes;
  logic [63:0] mid_bytes;
  logic [63:0] tail_bytes;

  modport source (output valid, output head_bytes, output mid_bytes, output tail_bytes,
                  input ready);
  modport sink (input valid, input head_bytes, input mid_bytes, input tail_bytes,
                output ready);
endinterface

@@ design/ycgdec_row_if.sv @@
interface ycgdec_row_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_index;
  logic [31:0] pixel_zero;
  logic [31:0] pixel_one;
  logic [31:0] pixel_two;
  logic [31:0] pixel_three;
  logic        last_row;

  modport source (output valid, output row_index, output pixel_zero, output pixel_one,
                  output pixel_two, output pixel_three, output last_row, input ready);
  modport sink (input valid, input row_index, input pixel_zero, input pixel_one,
                input pixel_two, input pixel_three, input last_row, output ready);
endinterface

@@ design/ycocg_block_pixel_decoder_core.sv @@
// a taken block is written into the queue, then its first row is registered out
// rows 0 to 3 of a block then follow in order, one row a cycle unless ready is low
// the queue lets the front end take the next block while the back end emits rows
// a two-entry queue between unpacking and conversion lets either side stall
// reset: asynchronous active low, clears queue, row counter, output valid and both
// config registers (4:2:0 layout, alpha off)
module ycocg_block_pixel_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ycgdec_blk_if.sink  blk_i,
  ycgdec_row_if.source row_o
);

  ycgdec_pkg::cfg_t   cfg_q, cfg_d;
  ycgdec_pkg::entry_t push_entry;
  ycgdec_pkg::entry_t head_entry;
  logic               push;
  logic               pop;
  logic               full;
  logic               head_valid;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        ycgdec_pkg::CfgFormatSelect: cfg_d.format_select = pwdata[0];
        ycgdec_pkg::CfgAlphaEnable:  cfg_d.alpha_enable  = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ycgdec_pkg::CfgFormatSelect: prdata = {31'b0, cfg_q.format_select};
      ycgdec_pkg::CfgAlphaEnable:  prdata = {31'b0, cfg_q.alpha_enable};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ycgdec_front u_front (
    .blk_i   (blk_i),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  ycgdec_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_entry)
  );

  ycgdec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .row_o        (row_o)
  );

endmodule

@@ design/ycgdec_front.sv @@
module ycgdec_front (
  ycgdec_blk_if.sink         blk_i,
  input  ycgdec_pkg::cfg_t   cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output ycgdec_pkg::entry_t entry_o
);

  logic [ycgdec_pkg::BlockBits-1:0] blk;

  assign blk = {blk_i.tail_bytes, blk_i.mid_bytes, blk_i.head_bytes};
  assign blk_i.ready = !full_i;
  assign push_o = blk_i.valid && !full_i;

  always_comb begin
    logic [4:0] cg_base;
    logic [4:0] luma_base;
    logic [4:0] alpha_base;
    logic [3:0] ci;
    logic [3:0] k;
    logic [3:0] a_nib;
    entry_o = '0;
    if (cfg_i.format_select == ycgdec_pkg::Layout422) begin
      cg_base    = ycgdec_pkg::CgBase422;
      luma_base  = ycgdec_pkg::LumaBase422;
      alpha_base = ycgdec_pkg::AlphaBase422;
    end else begin
      cg_base    = ycgdec_pkg::CgBase420;
      luma_base  = ycgdec_pkg::LumaBase420;
      alpha_base = ycgdec_pkg::AlphaBase420;
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        // chroma index: per pair in 4:2:2, per quad in 4:2:0
        if (cfg_i.format_select == ycgdec_pkg::Layout422) begin
          ci = 4'(r * 2 + c / 2);
        end else begin
          ci = 4'((r / 2) * 2 + c / 2);
        end
        k = ycgdec_pkg::NibOfPixel[r * 4 + c];
        entry_o.rows[r].co[c]   = ycgdec_pkg::get_nib(blk, ycgdec_pkg::CoBase, ci);
        entry_o.rows[r].cg[c]   = ycgdec_pkg::get_nib(blk, cg_base, ci);
        entry_o.rows[r].luma[c] = ycgdec_pkg::get_nib(blk, luma_base, k);
        a_nib = ycgdec_pkg::get_nib(blk, alpha_base, k);
        entry_o.rows[r].alpha[c] = cfg_i.alpha_enable ? {a_nib, a_nib}
                                                      : ycgdec_pkg::AlphaOpaque;
      end
    end
  end

endmodule

@@ design/ycgdec_queue.sv @@
module ycgdec_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ycgdec_pkg::entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output ycgdec_pkg::entry_t head_o
);

  ycgdec_pkg::entry_t mem_q [ycgdec_pkg::QueueDepth];

  logic [ycgdec_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ycgdec_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ycgdec_pkg::QueueCntW-1:0] count_q, count_d;

  assign full_o       = (count_q == ycgdec_pkg::QueueCntW'(ycgdec_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [ycgdec_pkg::QueuePtrW-1:0] next_ptr(
      logic [ycgdec_pkg::QueuePtrW-1:0] p);
    logic [ycgdec_pkg::QueuePtrW-1:0] res;
    if (p == ycgdec_pkg::QueuePtrW'(ycgdec_pkg::QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = p + 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ design/ycgdec_back.sv @@
module ycgdec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ycgdec_pkg::entry_t head_i,
  output logic               pop_o,
  ycgdec_row_if.source       row_o
);

  logic [1:0]  row_cnt_q, row_cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  row_idx_q;
  logic        last_q;
  logic [3:0][31:0] pix_q;
  logic [3:0][31:0] pix_d;
  logic        load;
  logic        advance;
  ycgdec_pkg::row_t cur_row;

  assign load    = !out_valid_q || row_o.ready;
  assign advance = head_valid_i && load;
  assign pop_o   = advance && (row_cnt_q == ycgdec_pkg::LastRow);
  assign cur_row = head_i.rows[row_cnt_q];

  always_comb begin
    row_cnt_d   = advance ? row_cnt_q + 2'd1 : row_cnt_q;
    out_valid_d = advance ? 1'b1 : (load ? 1'b0 : out_valid_q);
    for (int c = 0; c < 4; c++) begin
      pix_d[c] = ycgdec_pkg::make_pixel(cur_row.co[c], cur_row.cg[c], cur_row.luma[c],
                                        cur_row.alpha[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      row_idx_q <= row_cnt_q;
      last_q    <= (row_cnt_q == ycgdec_pkg::LastRow);
      pix_q     <= pix_d;
    end
  end

  assign row_o.valid       = out_valid_q;
  assign row_o.row_index   = row_idx_q;
  assign row_o.pixel_zero  = pix_q[0];
  assign row_o.pixel_one   = pix_q[1];
  assign row_o.pixel_two   = pix_q[2];
  assign row_o.pixel_three = pix_q[3];
  assign row_o.last_row    = last_q;

  // a partly drained block must still sit at the queue head
  a_partial_block_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q != 2'd0 |-> head_valid_i)
    else $error("row counter mid-block with empty queue");

  a_pop_rewinds_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> row_cnt_q == 2'd0)
    else $error("row counter not back at row 0 after block retired");

  a_last_flag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (last_q == (row_idx_q == ycgdec_pkg::LastRow)))
    else $error("last_row disagrees with row_index");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !row_o.ready |=> out_valid_q && $stable(row_idx_q))
    else $error("stalled output row lost or changed");

endmodule
